>>> hw/rtl/vfsr_pkg.sv
// vfsr_pkg: command codes, register indexes and regulation constants
// for the fan speed regulator; no dependencies
package vfsr_pkg;

  localparam int CMD_W   = 3;
  localparam int SPEED_W = 16;
  localparam int DUTY_W  = 7;
  localparam int MODE_W  = 2;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;
  localparam int ERR_W   = SPEED_W + 1;

  // request commands
  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PULSE      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_SPEED  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PRESET     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR_FAIL = 3'd4;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_MODE       = 2'd0;
  localparam logic [IDX_W-1:0] REG_SP_MAX     = 2'd1;
  localparam logic [IDX_W-1:0] REG_SP_NORMAL  = 2'd2;
  localparam logic [IDX_W-1:0] REG_SP_ECO     = 2'd3;

  // setpoint modes
  localparam logic [MODE_W-1:0] MODE_MAX    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ECO    = 2'd2;

  // register reset values
  localparam logic [SPEED_W-1:0] SP_MAX_RST    = 16'd1000;
  localparam logic [SPEED_W-1:0] SP_NORMAL_RST = 16'd700;
  localparam logic [SPEED_W-1:0] SP_ECO_RST    = 16'd500;

  // error bands
  localparam logic signed [ERR_W-1:0] ERR_BIG_POS   = 17'sd300;
  localparam logic signed [ERR_W-1:0] ERR_SMALL_POS = 17'sd80;
  localparam logic signed [ERR_W-1:0] ERR_BIG_NEG   = -17'sd100;
  localparam logic signed [ERR_W-1:0] ERR_SMALL_NEG = -17'sd80;

  // duty limits and steps
  localparam logic [DUTY_W-1:0] DUTY_MAX      = 7'd99;
  localparam logic [DUTY_W-1:0] DUTY_MIN      = 7'd5;
  localparam logic [DUTY_W-1:0] DUTY_START    = 7'd10;
  localparam logic [DUTY_W-1:0] STEP_BIG      = 7'd10;
  localparam logic [DUTY_W-1:0] STEP_MID      = 7'd3;
  localparam logic [DUTY_W-1:0] STEP_ONE      = 7'd1;

  localparam logic [SPEED_W-1:0] PULSE_SAT = 16'hFFFF;

endpackage

>>> hw/rtl/vacuum_fan_speed_regulator_top.sv
// vacuum_fan_speed_regulator_top: fan duty regulator from tach pulses
// depends on vfsr_pkg for command codes and constants
//
// result: registered on request accept, valid from the next cycle
// throughput: one request per cycle while results are taken; the state update
//   and result capture both happen in the single accept cycle, and a new
//   request enters in the same cycle that the waiting result is taken
// reset: synchronous active-high rst clears all control state, loads the
//   configuration defaults (normal mode, setpoints 1000/700/500), motor off
module vacuum_fan_speed_regulator_top #(
  parameter int WINDOW_TICKS = 20,
  parameter int FAIL_WINDOWS = 11
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_wr_en,
  input  logic [vfsr_pkg::IDX_W-1:0]      cfg_index,
  input  logic [vfsr_pkg::CFG_W-1:0]      cfg_data,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [vfsr_pkg::CMD_W-1:0]      cmd,
  input  logic [vfsr_pkg::SPEED_W-1:0]    speed_value,
  input  logic [vfsr_pkg::DUTY_W-1:0]     duty_value,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [vfsr_pkg::DUTY_W-1:0]     drive_duty,
  output logic                            motor_on,
  output logic                            fail_flag,
  output logic [vfsr_pkg::SPEED_W-1:0]    target_speed
);

  // tick counter just wide enough for the window, dead counter for the limit
  localparam int TICK_W = (WINDOW_TICKS > 1) ? $clog2(WINDOW_TICKS) : 1;
  localparam int DEAD_W = $clog2(FAIL_WINDOWS + 1);
  localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(WINDOW_TICKS - 1);
  localparam logic [DEAD_W-1:0] DEAD_LIMIT = DEAD_W'(FAIL_WINDOWS);

  // configuration registers
  logic [vfsr_pkg::MODE_W-1:0]  fan_mode;
  logic [vfsr_pkg::SPEED_W-1:0] setpoint_max;
  logic [vfsr_pkg::SPEED_W-1:0] setpoint_normal;
  logic [vfsr_pkg::SPEED_W-1:0] setpoint_eco;

  // regulator state
  logic [TICK_W-1:0]            tick_count, tick_count_next;
  logic [vfsr_pkg::SPEED_W-1:0] pulse_count, pulse_count_next;
  logic [vfsr_pkg::SPEED_W-1:0] speed_target, speed_target_next;
  logic [vfsr_pkg::DUTY_W-1:0]  duty_accum, duty_accum_next;
  logic [vfsr_pkg::DUTY_W-1:0]  applied_duty, applied_duty_next;
  logic                         driver_enabled, driver_enabled_next;
  logic [DEAD_W-1:0]            dead_windows, dead_windows_next;
  logic                         fail_latch, fail_latch_next;

  // window close datapath
  logic                                accept;
  logic                                window_close;
  logic [vfsr_pkg::SPEED_W-1:0]        win_target;
  logic signed [vfsr_pkg::ERR_W-1:0]   err;
  logic [vfsr_pkg::DUTY_W-1:0]         win_accum;
  logic [vfsr_pkg::DUTY_W-1:0]         win_floor;
  logic [DEAD_W-1:0]                   dead_inc;

  // the result register frees up when the consumer takes it
  assign in_ready     = !out_valid || out_ready;
  assign accept       = in_valid && in_ready;
  assign window_close = accept && (cmd == vfsr_pkg::CMD_TICK) && (tick_count >= TICK_LAST);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fan_mode        <= vfsr_pkg::MODE_NORMAL;
      setpoint_max    <= vfsr_pkg::SP_MAX_RST;
      setpoint_normal <= vfsr_pkg::SP_NORMAL_RST;
      setpoint_eco    <= vfsr_pkg::SP_ECO_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        vfsr_pkg::REG_MODE:      fan_mode        <= cfg_data[vfsr_pkg::MODE_W-1:0];
        vfsr_pkg::REG_SP_MAX:    setpoint_max    <= cfg_data;
        vfsr_pkg::REG_SP_NORMAL: setpoint_normal <= cfg_data;
        vfsr_pkg::REG_SP_ECO:    setpoint_eco    <= cfg_data;
        default: ;
      endcase
    end
  end

  // target reload from the current mode's setpoint; a zero target or an undefined mode keeps it
  always_comb begin
    win_target = speed_target;
    if (speed_target != '0) begin
      unique case (fan_mode)
        vfsr_pkg::MODE_MAX:    win_target = setpoint_max;
        vfsr_pkg::MODE_NORMAL: win_target = setpoint_normal;
        vfsr_pkg::MODE_ECO:    win_target = setpoint_eco;
        default:               win_target = speed_target;
      endcase
    end
  end

  assign err = $signed({1'b0, win_target}) - $signed({1'b0, pulse_count});

  // duty step by error band; accum stays at or below 99 so +10 cannot wrap
  always_comb begin
    win_accum = duty_accum;
    if (err > 0) begin
      if (err > vfsr_pkg::ERR_BIG_POS) begin
        win_accum = duty_accum + vfsr_pkg::STEP_BIG;
      end else if (err > vfsr_pkg::ERR_SMALL_POS) begin
        win_accum = duty_accum + vfsr_pkg::STEP_MID;
      end
      if (win_accum > vfsr_pkg::DUTY_MAX) begin
        win_accum = vfsr_pkg::DUTY_MAX;
      end
    end else if (err < vfsr_pkg::ERR_BIG_NEG) begin
      if (duty_accum > vfsr_pkg::DUTY_MIN) begin
        win_accum = duty_accum - vfsr_pkg::STEP_MID;
      end
    end else if (err < vfsr_pkg::ERR_SMALL_NEG) begin
      if (duty_accum != '0) begin
        win_accum = duty_accum - vfsr_pkg::STEP_ONE;
      end
    end
  end

  assign win_floor = (win_accum < vfsr_pkg::DUTY_MIN) ? vfsr_pkg::DUTY_MIN : win_accum;
  assign dead_inc  = dead_windows + DEAD_W'(1);

  // next state for one accepted request
  always_comb begin
    tick_count_next     = tick_count;
    pulse_count_next    = pulse_count;
    speed_target_next   = speed_target;
    duty_accum_next     = duty_accum;
    applied_duty_next   = applied_duty;
    driver_enabled_next = driver_enabled;
    dead_windows_next   = dead_windows;
    fail_latch_next     = fail_latch;
    if (accept) begin
      unique case (cmd)
        vfsr_pkg::CMD_TICK: begin
          if (tick_count >= TICK_LAST) begin
            tick_count_next  = '0;
            pulse_count_next = '0;
            if (driver_enabled) begin
              speed_target_next = win_target;
              duty_accum_next   = win_floor;
              applied_duty_next = win_floor;
              if (pulse_count == '0) begin
                // a window with no tach edges while driving
                if (dead_inc >= DEAD_LIMIT) begin
                  dead_windows_next = '0;
                  fail_latch_next   = 1'b1;
                end else begin
                  dead_windows_next = dead_inc;
                end
              end else begin
                dead_windows_next = '0;
              end
            end else begin
              dead_windows_next = '0;
            end
          end else begin
            tick_count_next = tick_count + TICK_W'(1);
          end
        end
        vfsr_pkg::CMD_PULSE: begin
          if (pulse_count != vfsr_pkg::PULSE_SAT) begin
            pulse_count_next = pulse_count + 16'd1;
          end
        end
        vfsr_pkg::CMD_SET_SPEED: begin
          speed_target_next = speed_value;
          if (speed_value == '0) begin
            driver_enabled_next = 1'b0;
          end else begin
            driver_enabled_next = 1'b1;
            if (applied_duty < vfsr_pkg::DUTY_START) begin
              applied_duty_next = vfsr_pkg::DUTY_START;
            end
          end
        end
        vfsr_pkg::CMD_PRESET: begin
          duty_accum_next = (duty_value > vfsr_pkg::DUTY_MAX) ? vfsr_pkg::DUTY_MAX : duty_value;
        end
        vfsr_pkg::CMD_CLEAR_FAIL: begin
          fail_latch_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      pulse_count    <= '0;
      speed_target   <= '0;
      duty_accum     <= '0;
      applied_duty   <= '0;
      driver_enabled <= 1'b0;
      dead_windows   <= '0;
      fail_latch     <= 1'b0;
    end else begin
      tick_count     <= tick_count_next;
      pulse_count    <= pulse_count_next;
      speed_target   <= speed_target_next;
      duty_accum     <= duty_accum_next;
      applied_duty   <= applied_duty_next;
      driver_enabled <= driver_enabled_next;
      dead_windows   <= dead_windows_next;
      fail_latch     <= fail_latch_next;
    end
  end

  // result register: snapshot of the updated state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drive_duty   <= applied_duty_next;
      motor_on     <= driver_enabled_next;
      fail_flag    <= fail_latch_next;
      target_speed <= speed_target_next;
    end
  end

`ifndef SYNTH
  a_no_accept_when_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted while result held");

  a_duty_in_range: assert property (@(posedge clk) disable iff (rst)
    applied_duty <= vfsr_pkg::DUTY_MAX && duty_accum <= vfsr_pkg::DUTY_MAX)
    else $error("duty above limit");

  a_running_duty_floor: assert property (@(posedge clk) disable iff (rst)
    driver_enabled |-> applied_duty >= vfsr_pkg::DUTY_MIN)
    else $error("motor running below minimum duty");

  a_dead_below_limit: assert property (@(posedge clk) disable iff (rst)
    dead_windows < DEAD_LIMIT)
    else $error("dead window count reached limit");

  a_fail_from_window: assert property (@(posedge clk) disable iff (rst)
    $rose(fail_latch) |-> $past(window_close) && $past(pulse_count) == '0)
    else $error("fail flag set outside a silent window");

  a_pulses_cleared: assert property (@(posedge clk) disable iff (rst)
    window_close |=> pulse_count == '0)
    else $error("pulse count not cleared at window close");
`endif

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// testbench: directed and random requests for vacuum_fan_speed_regulator_top,
// each result checked against a hand-written value or a duty model kept in step
// with every request; depends on vfsr_pkg and vacuum_fan_speed_regulator_top

module testbench;

  localparam int WINDOW_TICKS  = 20;
  localparam int FAIL_WINDOWS  = 11;
  localparam int PHASE_REQS    = 70;      // random requests per register setting
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 4;       // idle margin after the last result
  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int MAX_REPORTS   = 10;

  // command and mode codes the block leaves undefined
  localparam logic [vfsr_pkg::CMD_W-1:0]  CMD_RSVD5  = 3'd5;
  localparam logic [vfsr_pkg::CMD_W-1:0]  CMD_RSVD6  = 3'd6;
  localparam logic [vfsr_pkg::CMD_W-1:0]  CMD_RSVD7  = 3'd7;
  localparam logic [vfsr_pkg::MODE_W-1:0] MODE_UNDEF = 2'd3;

  typedef struct packed {
    logic [vfsr_pkg::DUTY_W-1:0]  duty;
    logic                         motor;
    logic                         fail;
    logic [vfsr_pkg::SPEED_W-1:0] target;
  } fan_status_t;

  typedef struct packed {
    logic [vfsr_pkg::CMD_W-1:0]   cmd;
    logic [vfsr_pkg::SPEED_W-1:0] speed;
    logic [vfsr_pkg::DUTY_W-1:0]  duty;
    logic                         typed;   // want holds a hand-written result
    fan_status_t                  want;
  } stim_row_t;

  typedef enum logic [1:0] {MIX_SEND_LIGHT, MIX_RECV_LIGHT, MIX_NO_IDLE} idle_mix_t;

  typedef struct packed {
    logic [vfsr_pkg::MODE_W-1:0]  mode;
    logic [vfsr_pkg::SPEED_W-1:0] sp_max;
    logic [vfsr_pkg::SPEED_W-1:0] sp_normal;
    logic [vfsr_pkg::SPEED_W-1:0] sp_eco;
    idle_mix_t                    mix;
  } phase_cfg_t;

  // directed requests; the typed rows carry a hand-written result
  localparam stim_row_t DIRECTED[17] = '{
    '{vfsr_pkg::CMD_TICK,       16'h0000, 7'h00,  1'b1, '{7'd0,  1'b0, 1'b0, 16'd0}},
    '{vfsr_pkg::CMD_PULSE,      16'hFFFF, 7'h7F,  1'b1, '{7'd0,  1'b0, 1'b0, 16'd0}},
    '{vfsr_pkg::CMD_CLEAR_FAIL, 16'hFFFF, 7'h7F,  1'b1, '{7'd0,  1'b0, 1'b0, 16'd0}},
    // undefined commands change nothing but still answer
    '{CMD_RSVD5,                16'hFFFF, 7'h7F,  1'b1, '{7'd0,  1'b0, 1'b0, 16'd0}},
    '{CMD_RSVD6,                16'h5555, 7'h2A,  1'b1, '{7'd0,  1'b0, 1'b0, 16'd0}},
    '{CMD_RSVD7,                16'hAAAA, 7'h55,  1'b1, '{7'd0,  1'b0, 1'b0, 16'd0}},
    // preset above 99 saturates the accumulator, applied duty untouched
    '{vfsr_pkg::CMD_PRESET,     16'h0000, 7'h7F,  1'b1, '{7'd0,  1'b0, 1'b0, 16'd0}},
    // nonzero speed starts the motor at duty 10
    '{vfsr_pkg::CMD_SET_SPEED,  16'h0001, 7'h00,  1'b1, '{7'd10, 1'b1, 1'b0, 16'd1}},
    '{vfsr_pkg::CMD_SET_SPEED,  16'h0000, 7'h7F,  1'b1, '{7'd10, 1'b0, 1'b0, 16'd0}},
    '{vfsr_pkg::CMD_PRESET,     16'hFFFF, 7'd100, 1'b1, '{7'd10, 1'b0, 1'b0, 16'd0}},
    '{vfsr_pkg::CMD_SET_SPEED,  16'hFFFF, 7'h00,  1'b1, '{7'd10, 1'b1, 1'b0, 16'hFFFF}},
    '{vfsr_pkg::CMD_PRESET,     16'h0000, 7'd0,   1'b1, '{7'd10, 1'b1, 1'b0, 16'hFFFF}},
    '{vfsr_pkg::CMD_PRESET,     16'h0000, 7'd99,  1'b1, '{7'd10, 1'b1, 1'b0, 16'hFFFF}},
    '{vfsr_pkg::CMD_PULSE,      16'h1234, 7'h11,  1'b0, '0},
    '{vfsr_pkg::CMD_TICK,       16'hFFFF, 7'h7F,  1'b0, '0},
    '{vfsr_pkg::CMD_SET_SPEED,  16'h8000, 7'h40,  1'b0, '0},
    '{vfsr_pkg::CMD_CLEAR_FAIL, 16'h7FFF, 7'h3F,  1'b0, '0}
  };

  // register settings walked by the random part, extremes included
  localparam phase_cfg_t PHASES[6] = '{
    '{vfsr_pkg::MODE_NORMAL, 16'hFFFF, 16'd40,   16'd0,    MIX_SEND_LIGHT},
    '{vfsr_pkg::MODE_MAX,    16'hFFFF, 16'd0,    16'd500,  MIX_SEND_LIGHT},
    '{vfsr_pkg::MODE_ECO,    16'd1000, 16'd700,  16'd0,    MIX_RECV_LIGHT},
    '{MODE_UNDEF,            16'd0,    16'hFFFF, 16'd250,  MIX_RECV_LIGHT},
    '{vfsr_pkg::MODE_ECO,    16'd0,    16'd0,    16'd380,  MIX_NO_IDLE},
    '{vfsr_pkg::MODE_NORMAL, 16'd123,  16'd200,  16'hFFFF, MIX_NO_IDLE}
  };

  // speed errors on both sides of every regulation band edge
  localparam int BAND_EDGES[12] = '{301, 300, 81, 80, 1, 0, -1, -80, -81, -100, -101, -200};

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_wr_en = 1'b0;
  logic [vfsr_pkg::IDX_W-1:0]    cfg_index = '0;
  logic [vfsr_pkg::CFG_W-1:0]    cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [vfsr_pkg::CMD_W-1:0]    cmd = '0;
  logic [vfsr_pkg::SPEED_W-1:0]  speed_value = '0;
  logic [vfsr_pkg::DUTY_W-1:0]   duty_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [vfsr_pkg::DUTY_W-1:0]   drive_duty;
  logic                          motor_on;
  logic                          fail_flag;
  logic [vfsr_pkg::SPEED_W-1:0]  target_speed;

  // duty model state and its copy of the registers
  int                            tick_cnt;
  int                            pulse_cnt;
  int                            duty_accum;
  int                            duty_applied;
  int                            dead_cnt;
  logic [vfsr_pkg::SPEED_W-1:0]  fan_target;
  logic                          motor_en;
  logic                          fail_latched;
  logic [vfsr_pkg::MODE_W-1:0]   reg_mode;
  logic [vfsr_pkg::SPEED_W-1:0]  reg_sp_max;
  logic [vfsr_pkg::SPEED_W-1:0]  reg_sp_normal;
  logic [vfsr_pkg::SPEED_W-1:0]  reg_sp_eco;

  fan_status_t         status_due[$];   // results owed by the block, oldest first
  fan_status_t         req_want;
  logic                req_typed = 1'b0;
  int                  fail_count = 0;
  int                  items_sent = 0;
  int                  cycle_count = 0;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  hold_asks = 0;
  int                  hold_seen = 0;
  int                  hold_left = 0;

  vacuum_fan_speed_regulator_top #(
    .WINDOW_TICKS(WINDOW_TICKS),
    .FAIL_WINDOWS(FAIL_WINDOWS)
  ) u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // advance the duty model by one request and return the status it reports
  function automatic fan_status_t fan_step(input logic [vfsr_pkg::CMD_W-1:0] c,
                                           input logic [vfsr_pkg::SPEED_W-1:0] spd,
                                           input logic [vfsr_pkg::DUTY_W-1:0] dv);
    int err;
    case (c)
      vfsr_pkg::CMD_TICK: begin
        if (tick_cnt >= WINDOW_TICKS - 1) begin
          tick_cnt = 0;
          // window closes: regulate only while the driver runs
          if (motor_en) begin
            // a zero target is never reloaded, nor is anything in the undefined mode
            if (fan_target != '0) begin
              case (reg_mode)
                vfsr_pkg::MODE_MAX:    fan_target = reg_sp_max;
                vfsr_pkg::MODE_NORMAL: fan_target = reg_sp_normal;
                vfsr_pkg::MODE_ECO:    fan_target = reg_sp_eco;
                default:     ;
              endcase
            end
            err = int'(fan_target) - pulse_cnt;
            if (err > 0) begin
              if (err > 300) duty_accum += 10;
              else if (err > 80) duty_accum += 3;
              if (duty_accum > 99) duty_accum = 99;
            end else if (err < -100) begin
              if (duty_accum > 5) duty_accum -= 3;
            end else if (err < -80) begin
              if (duty_accum > 0) duty_accum -= 1;
            end
            if (duty_accum < 5) duty_accum = 5;
            duty_applied = duty_accum;
            // consecutive windows with no tach pulse latch the failure
            if (pulse_cnt == 0) begin
              dead_cnt++;
              if (dead_cnt >= FAIL_WINDOWS) begin
                dead_cnt = 0;
                fail_latched = 1'b1;
              end
            end else begin
              dead_cnt = 0;
            end
          end else begin
            dead_cnt = 0;
          end
          pulse_cnt = 0;
        end else begin
          tick_cnt++;
        end
      end
      vfsr_pkg::CMD_PULSE: begin
        if (pulse_cnt < 65535) pulse_cnt++;
      end
      vfsr_pkg::CMD_SET_SPEED: begin
        fan_target = spd;
        if (spd == '0) begin
          motor_en = 1'b0;
        end else begin
          if (duty_applied < 10) duty_applied = 10;
          motor_en = 1'b1;
        end
      end
      vfsr_pkg::CMD_PRESET: begin
        duty_accum = (dv > 7'd99) ? 99 : int'(dv);
      end
      vfsr_pkg::CMD_CLEAR_FAIL: begin
        fail_latched = 1'b0;
      end
      default: ;
    endcase
    return '{vfsr_pkg::DUTY_W'(duty_applied), motor_en, fail_latched, fan_target};
  endfunction

  function automatic logic [vfsr_pkg::SPEED_W-1:0] pick_speed();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return vfsr_pkg::SPEED_W'(1);
    if (r < 7) return vfsr_pkg::SPEED_W'($urandom_range(400, 1));
    return vfsr_pkg::SPEED_W'($urandom);
  endfunction

  task automatic set_mix(input idle_mix_t m);
    case (m)
      MIX_SEND_LIGHT: begin
        send_idle_pct = 9;
        recv_idle_pct = 46;
      end
      MIX_RECV_LIGHT: begin
        send_idle_pct = 46;
        recv_idle_pct = 9;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // offer one request from a falling edge; returns at the falling edge after accept
  task automatic send_item(input logic [vfsr_pkg::CMD_W-1:0] c,
                           input logic [vfsr_pkg::SPEED_W-1:0] spd,
                           input logic [vfsr_pkg::DUTY_W-1:0] dv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cmd = c;
    speed_value = spd;
    duty_value = dv;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // finish the current control window with a given number of tach pulses
  // spread among the ticks, the last tick closing the window
  task automatic run_window(input int pulses);
    int ticks_left;
    int pulses_left;
    ticks_left = WINDOW_TICKS - tick_cnt;
    pulses_left = pulses;
    while (ticks_left > 0) begin
      if (pulses_left > 0 && (ticks_left == 1 ||
          $urandom_range(ticks_left + pulses_left - 1) < pulses_left)) begin
        send_item(vfsr_pkg::CMD_PULSE, vfsr_pkg::SPEED_W'($urandom),
                  vfsr_pkg::DUTY_W'($urandom));
        pulses_left--;
      end else begin
        send_item(vfsr_pkg::CMD_TICK, vfsr_pkg::SPEED_W'($urandom),
                  vfsr_pkg::DUTY_W'($urandom));
        ticks_left--;
      end
    end
  endtask

  // register write, mirrored into the model's copy of the registers
  task automatic write_reg(input logic [vfsr_pkg::IDX_W-1:0] idx,
                           input logic [vfsr_pkg::CFG_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      vfsr_pkg::REG_MODE:      reg_mode = val[vfsr_pkg::MODE_W-1:0];
      vfsr_pkg::REG_SP_MAX:    reg_sp_max = val;
      vfsr_pkg::REG_SP_NORMAL: reg_sp_normal = val;
      default:                 reg_sp_eco = val;
    endcase
    @(negedge clk);
  endtask

  // stop offering and wait until every owed result has come back
  task automatic settle();
    in_valid = 1'b0;
    while (status_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result side: random back-pressure, or a long hold-off when asked for
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // at each rising edge: check a returned result, then predict for an accepted request
  always @(posedge clk) begin
    fan_status_t got;
    fan_status_t want;
    fan_status_t model;
    got = '{drive_duty, motor_on, fail_flag, target_speed};
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: duty=%0d motor=%0d fail=%0d target=%0d",
                     got.duty, got.motor, got.fail, got.target);
        end else begin
          want = status_due.pop_front();
          if (got.duty !== want.duty || got.motor !== want.motor ||
              got.fail !== want.fail || got.target !== want.target) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       want.duty, want.motor, want.fail, want.target,
                       got.duty, got.motor, got.fail, got.target);
          end
        end
      end
      if (in_valid && in_ready) begin
        model = fan_step(cmd, speed_value, duty_value);
        status_due.push_back(req_typed ? req_want : model);
      end
    end
  end

  // run limit, far above the slowest correct run
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    phase_cfg_t pc;
    int eff;
    int pulses;
    int phase_end;
    int n;

    // model state matches the block after reset
    reg_mode = vfsr_pkg::MODE_NORMAL;
    reg_sp_max = vfsr_pkg::SP_MAX_RST;
    reg_sp_normal = vfsr_pkg::SP_NORMAL_RST;
    reg_sp_eco = vfsr_pkg::SP_ECO_RST;
    tick_cnt = 0;
    pulse_cnt = 0;
    duty_accum = 0;
    duty_applied = 0;
    dead_cnt = 0;
    fan_target = '0;
    motor_en = 1'b0;
    fail_latched = 1'b0;
    set_mix(MIX_SEND_LIGHT);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part from the reset register values
    foreach (DIRECTED[i]) begin
      req_typed = DIRECTED[i].typed;
      req_want = DIRECTED[i].want;
      send_item(DIRECTED[i].cmd, DIRECTED[i].speed, DIRECTED[i].duty);
    end
    req_typed = 1'b0;
    settle();

    // random part, one register setting after another while the block is idle
    for (int ph = 0; ph < 6; ph++) begin
      pc = PHASES[ph];
      write_reg(vfsr_pkg::REG_MODE, vfsr_pkg::CFG_W'(pc.mode));
      write_reg(vfsr_pkg::REG_SP_MAX, pc.sp_max);
      write_reg(vfsr_pkg::REG_SP_NORMAL, pc.sp_normal);
      write_reg(vfsr_pkg::REG_SP_ECO, pc.sp_eco);
      cfg_wr_en = 1'b0;
      set_mix(pc.mix);

      // long result hold-off so the block fills up and stalls its requests
      if (ph == 0 || ph == 4) hold_asks++;

      // stretch of pulse-free windows with the motor on, around the fail threshold
      if (ph == 1 || ph == 4) begin
        n = FAIL_WINDOWS - 1 + $urandom_range(3);
        send_item(vfsr_pkg::CMD_SET_SPEED, vfsr_pkg::SPEED_W'($urandom_range(65535, 1)),
                  vfsr_pkg::DUTY_W'($urandom));
        repeat (n) run_window(0);
        send_item(vfsr_pkg::CMD_CLEAR_FAIL, vfsr_pkg::SPEED_W'($urandom),
                  vfsr_pkg::DUTY_W'($urandom));
      end

      phase_end = items_sent + PHASE_REQS;
      while (items_sent < phase_end) begin
        if ($urandom_range(99) < 80) begin
          // well-formed window: optional set-up requests, then pulses and ticks
          if ($urandom_range(99) < 30)
            send_item(vfsr_pkg::CMD_SET_SPEED, pick_speed(), vfsr_pkg::DUTY_W'($urandom));
          if ($urandom_range(99) < 10)
            send_item(vfsr_pkg::CMD_PRESET, vfsr_pkg::SPEED_W'($urandom),
                      vfsr_pkg::DUTY_W'($urandom));
          if ($urandom_range(99) < 10)
            send_item(vfsr_pkg::CMD_CLEAR_FAIL, vfsr_pkg::SPEED_W'($urandom),
                      vfsr_pkg::DUTY_W'($urandom));
          // target the window will regulate against
          eff = int'(fan_target);
          if (fan_target != '0) begin
            case (reg_mode)
              vfsr_pkg::MODE_MAX:    eff = int'(reg_sp_max);
              vfsr_pkg::MODE_NORMAL: eff = int'(reg_sp_normal);
              vfsr_pkg::MODE_ECO:    eff = int'(reg_sp_eco);
              default:     ;
            endcase
          end
          if ($urandom_range(3) == 0) begin
            pulses = 0;
          end else begin
            pulses = eff - BAND_EDGES[$urandom_range(11)];
            if (pulses < 0 || pulses > 200) pulses = $urandom_range(30);
          end
          run_window(pulses);
        end else begin
          // noise: any command with any field values
          send_item(vfsr_pkg::CMD_W'($urandom_range(7)), vfsr_pkg::SPEED_W'($urandom),
                    vfsr_pkg::DUTY_W'($urandom));
        end
      end
      settle();
    end

    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> vacuum_fan_speed_regulator_top.f
hw/rtl/vfsr_pkg.sv
hw/rtl/vacuum_fan_speed_regulator_top.sv
sim/testbench.sv
